/* rtl/lpcm_pkg.sv */
// Shared types, constants and the arctangent table for the lidar point converter.
package lpcm_pkg;

   // Field widths of the item, result and register formats.
   localparam int RANGE_W     = 16;
   localparam int ANGLE_REG_W = 20;
   localparam int STEP_W      = 16;
   localparam int POSE_W      = 19;
   localparam int TAG_W       = 8;
   localparam int POINT_W     = 20;

   // Configuration port geometry: eight 32-bit registers at word addresses.
   localparam int CFG_AW = 5;
   localparam int CFG_DW = 32;

   // Rotation datapath geometry.
   localparam int ANGLE_Q_BITS = 24;   // fraction bits of the rotation angle, in degrees
   localparam int CORDIC_XY_W  = 36;   // Q16 millimetres with growth headroom
   localparam int CORDIC_Z_W   = 33;   // residual angle, holds +-135 degrees in Q24
   localparam int ATAN_IDX_W   = 5;
   localparam int ROUND_BITS   = 16;   // fraction bits dropped at the output

   // Inverse rotation gain in Q30; the range is pre-scaled by it.
   localparam int GAIN_Q_W    = 30;
   localparam logic [GAIN_Q_W-1:0] INV_GAIN_Q30 = 30'd652032874;
   localparam int GAIN_PROD_W = RANGE_W + GAIN_Q_W;
   localparam int GAIN_SHIFT  = 14;
   localparam int X0_W        = GAIN_PROD_W - GAIN_SHIFT;

   typedef enum logic [2:0] {
      REG_ANGLE_MIN    = 3'd0,
      REG_ANGLE_MAX    = 3'd1,
      REG_NEAR_LIMIT   = 3'd2,
      REG_FAR_LIMIT    = 3'd3,
      REG_POSE_X       = 3'd4,
      REG_POSE_Y       = 3'd5,
      REG_POSE_HEADING = 3'd6,
      REG_SENSOR_TAG   = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic        [RANGE_W-1:0]     range_mm;
      logic                          first_of_scan;
      logic signed [ANGLE_REG_W-1:0] scan_start_angle;
      logic signed [STEP_W-1:0]      angle_step;
   } req_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] point_x_mm;
      logic signed [POINT_W-1:0] point_y_mm;
      logic        [TAG_W-1:0]   point_sensor;
   } rsp_type;

   typedef struct packed {
      logic signed [ANGLE_REG_W-1:0] angle_min;
      logic signed [ANGLE_REG_W-1:0] angle_max;
      logic        [RANGE_W-1:0]     near_limit_mm;
      logic        [RANGE_W-1:0]     far_limit_mm;
      logic signed [POSE_W-1:0]      pose_x_mm;
      logic signed [POSE_W-1:0]      pose_y_mm;
      logic signed [ANGLE_REG_W-1:0] pose_heading;
      logic        [TAG_W-1:0]       sensor_tag;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      angle_min:     20'shA6000,
      angle_max:     20'sh5A000,
      near_limit_mm: 16'h0000,
      far_limit_mm:  16'hFFFF,
      pose_x_mm:     19'sh00000,
      pose_y_mm:     19'sh00000,
      pose_heading:  20'sh00000,
      sensor_tag:    8'h00
   };

   // Sequencer to rotation unit.
   typedef struct packed {
      logic start;
   } cordic_ctl_type;

   // Rotation unit to sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } cordic_sts_type;

   // Arctangent of 2^-idx in units of 2^-24 degree.
   function automatic logic signed [31:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [31:0] val;
      case (idx)
         5'd0:    val = 32'sd754974720;
         5'd1:    val = 32'sd445687602;
         5'd2:    val = 32'sd235489088;
         5'd3:    val = 32'sd119537938;
         5'd4:    val = 32'sd60000934;
         5'd5:    val = 32'sd30029717;
         5'd6:    val = 32'sd15018523;
         5'd7:    val = 32'sd7509720;
         5'd8:    val = 32'sd3754917;
         5'd9:    val = 32'sd1877466;
         5'd10:   val = 32'sd938734;
         5'd11:   val = 32'sd469367;
         5'd12:   val = 32'sd234684;
         5'd13:   val = 32'sd117342;
         5'd14:   val = 32'sd58671;
         5'd15:   val = 32'sd29335;
         5'd16:   val = 32'sd14668;
         5'd17:   val = 32'sd7334;
         5'd18:   val = 32'sd3667;
         5'd19:   val = 32'sd1833;
         5'd20:   val = 32'sd917;
         5'd21:   val = 32'sd458;
         5'd22:   val = 32'sd229;
         5'd23:   val = 32'sd115;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

endpackage

/* rtl/lpcm_csr.sv */
// Configuration register file behind an APB-style write and read port.
module lpcm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpcm_pkg::CFG_AW-1:0]   csr_paddr,
   input  logic [lpcm_pkg::CFG_DW-1:0]   csr_pwdata,
   output logic [lpcm_pkg::CFG_DW-1:0]   csr_prdata,
   output logic                          csr_pready,
   output lpcm_pkg::cfg_type             cfg
);
   import lpcm_pkg::*;

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   // Registers sit on word addresses; the low address bits are ignored.
   assign reg_idx    = reg_idx_type'(csr_paddr[CFG_AW-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write decode: each register keeps only its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ANGLE_MIN:    cfg_in.angle_min     = csr_pwdata[ANGLE_REG_W-1:0];
            REG_ANGLE_MAX:    cfg_in.angle_max     = csr_pwdata[ANGLE_REG_W-1:0];
            REG_NEAR_LIMIT:   cfg_in.near_limit_mm = csr_pwdata[RANGE_W-1:0];
            REG_FAR_LIMIT:    cfg_in.far_limit_mm  = csr_pwdata[RANGE_W-1:0];
            REG_POSE_X:       cfg_in.pose_x_mm     = csr_pwdata[POSE_W-1:0];
            REG_POSE_Y:       cfg_in.pose_y_mm     = csr_pwdata[POSE_W-1:0];
            REG_POSE_HEADING: cfg_in.pose_heading  = csr_pwdata[ANGLE_REG_W-1:0];
            REG_SENSOR_TAG:   cfg_in.sensor_tag    = csr_pwdata[TAG_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Read mux returns the raw register bits, zero-extended.
   always_comb begin
      case (reg_idx)
         REG_ANGLE_MIN:    csr_prdata = {{(CFG_DW-ANGLE_REG_W){1'b0}}, cfg_ff.angle_min};
         REG_ANGLE_MAX:    csr_prdata = {{(CFG_DW-ANGLE_REG_W){1'b0}}, cfg_ff.angle_max};
         REG_NEAR_LIMIT:   csr_prdata = {{(CFG_DW-RANGE_W){1'b0}}, cfg_ff.near_limit_mm};
         REG_FAR_LIMIT:    csr_prdata = {{(CFG_DW-RANGE_W){1'b0}}, cfg_ff.far_limit_mm};
         REG_POSE_X:       csr_prdata = {{(CFG_DW-POSE_W){1'b0}}, cfg_ff.pose_x_mm};
         REG_POSE_Y:       csr_prdata = {{(CFG_DW-POSE_W){1'b0}}, cfg_ff.pose_y_mm};
         REG_POSE_HEADING: csr_prdata = {{(CFG_DW-ANGLE_REG_W){1'b0}}, cfg_ff.pose_heading};
         REG_SENSOR_TAG:   csr_prdata = {{(CFG_DW-TAG_W){1'b0}}, cfg_ff.sensor_tag};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/lpcm_cordic.sv */
// Iterative rotation-mode CORDIC: one shift-add micro-rotation per cycle.
module lpcm_cordic #(
   parameter int ITERS = 16
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  lpcm_pkg::cordic_ctl_type                  ctl,
   output lpcm_pkg::cordic_sts_type                  sts,
   input  logic signed [lpcm_pkg::CORDIC_XY_W-1:0]   x_start,
   input  logic signed [lpcm_pkg::CORDIC_Z_W-1:0]    z_start,
   output logic signed [lpcm_pkg::CORDIC_XY_W-1:0]   x_out,
   output logic signed [lpcm_pkg::CORDIC_XY_W-1:0]   y_out
);
   import lpcm_pkg::*;

   localparam int CNT_W = $clog2(ITERS);

   logic signed [CORDIC_XY_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_Z_W-1:0]  z_ff, z_in;
   logic        [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                          busy_ff, busy_in, done_ff, done_in;
   logic signed [CORDIC_XY_W-1:0] dx, dy;
   logic signed [CORDIC_Z_W-1:0]  step_angle;

   // Shifted cross terms and the table angle for the current iteration.
   assign dx         = y_ff >>> cnt_ff;
   assign dy         = x_ff >>> cnt_ff;
   assign step_angle = CORDIC_Z_W'(atan_q24(ATAN_IDX_W'(cnt_ff)));

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign x_out    = x_ff;
   assign y_out    = y_ff;

   // Load on start, then rotate toward a zero residual angle.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = x_start;
         y_in    = '0;
         z_in    = z_start;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_Z_W-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         if (cnt_ff == CNT_W'(ITERS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

/* rtl/lidar_polar_to_cartesian_masker.sv */
// Lidar range sample to world point converter with angle and range masking.
//
// Items arrive on the req_ channel (valid/ready), one range sample each. A
// sample flagged first_of_scan loads the beam angle from its start angle;
// every other sample adds its angle step. The beam angle saturates at
// +-360 degrees. Samples with zero range or outside the configured angle
// and near/far windows give no result. A kept sample becomes one point on
// the rsp_ channel: rotated by the heading, offset by the pose, tagged.
//
// Sequence: a dropped sample returns to idle straight after the check state. A
// kept sample passes the check state, the M steps of the heading-wrap reduction
// (4 at ANGLE_FRAC_BITS = 10), the fold, the rotation, the rounding and the
// output state before rsp_valid rises. A new item is taken in the cycle the
// point appears, so the block works on one sample at a time. The rotation is
// done by the single CORDIC unit, which does one micro-rotation a cycle.
//
// Reset clears the beam angle to zero, loads the register defaults and
// empties the output register. The point waits in the output register while
// the receiver stalls; the next sample may already be accepted and worked
// on, but its point is held back until the output register is free.
module lidar_polar_to_cartesian_masker #(
   parameter int ANGLE_FRAC_BITS = 10,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  lpcm_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output lpcm_pkg::rsp_type             rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [lpcm_pkg::CFG_AW-1:0]   csr_paddr,
   input  logic [lpcm_pkg::CFG_DW-1:0]   csr_pwdata,
   output logic [lpcm_pkg::CFG_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import lpcm_pkg::*;

   // Angle geometry in units of 2^-ANGLE_FRAC_BITS degree.
   localparam int FULL      = 360 * (2 ** ANGLE_FRAC_BITS);
   localparam int HALF      = FULL / 2;
   localparam int QUARTER   = FULL / 4;
   localparam int THREE_Q   = 3 * QUARTER;
   localparam int ANGLE_W   = ANGLE_FRAC_BITS + 10;
   localparam int SUM_W     = ((ANGLE_W > ANGLE_REG_W) ? ANGLE_W : ANGLE_REG_W) + 1;
   // The heading wrap: bias the sum positive, then subtract FULL << k for
   // k from MOD_TOP down to zero.
   localparam int HEAD_SPAN = 2 ** (ANGLE_REG_W - 1);
   localparam int WRAPS     = 1 + (HEAD_SPAN + FULL - 1) / FULL;
   localparam int MOD_TOP   = $clog2(2 * WRAPS);
   localparam int MOD_W     = $clog2(FULL * (2 ** (MOD_TOP + 1))) + 2;
   localparam int MODK_W    = $clog2(MOD_TOP + 1);
   // Output rounding and saturation.
   localparam int RND_W     = CORDIC_XY_W + 1;
   localparam int FIN_W     = RND_W - ROUND_BITS + 1;
   localparam int POINT_MAX = 2 ** (POINT_W - 1) - 1;
   localparam int POINT_MIN = -(2 ** (POINT_W - 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_MOD,
      S_FOLD,
      S_ROT,
      S_RND,
      S_OUT
   } state_type;

   cfg_type                     cfg;
   cordic_ctl_type              cordic_ctl;
   cordic_sts_type              cordic_sts;

   state_type                   state_ff, state_in;
   logic signed [ANGLE_W-1:0]   beam_ff, beam_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_ff, rsp_in;

   logic        [RANGE_W-1:0]   range_ff, range_in;
   logic signed [MOD_W-1:0]     wrap_ff, wrap_in;
   logic        [MODK_W-1:0]    k_ff, k_in;
   logic        [X0_W-1:0]      x0_ff, x0_in;
   logic                        neg_ff, neg_in;
   logic signed [RND_W-1:0]     xr_ff, xr_in, yr_ff, yr_in;

   logic                        accept;
   logic signed [SUM_W-1:0]     beam_sum;
   logic                        angle_ok, range_ok;
   logic        [GAIN_PROD_W-1:0] gain_prod;
   logic signed [MOD_W-1:0]     wrap_sub;
   logic signed [MOD_W-1:0]     fold_angle;
   logic                        fold_neg;
   logic signed [CORDIC_XY_W-1:0] x_start, cx, cy;
   logic signed [CORDIC_Z_W-1:0]  z_start;
   logic signed [FIN_W-1:0]     fin_x, fin_y;
   logic                        out_free;

   function automatic logic signed [POINT_W-1:0] sat_point(input logic signed [FIN_W-1:0] v);
      logic signed [POINT_W-1:0] r;
      if (v > FIN_W'(POINT_MAX)) begin
         r = POINT_W'(POINT_MAX);
      end else if (v < FIN_W'(POINT_MIN)) begin
         r = POINT_W'(POINT_MIN);
      end else begin
         r = v[POINT_W-1:0];
      end
      return r;
   endfunction

   lpcm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpcm_cordic #(
      .ITERS (TRIG_ITERATIONS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctl     (cordic_ctl),
      .sts     (cordic_sts),
      .x_start (x_start),
      .z_start (z_start),
      .x_out   (cx),
      .y_out   (cy)
   );

   assign req_ready = (state_ff == S_IDLE) && !reset;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Beam angle update: load or step; the sequencer saturates the sum to a full turn.
   always_comb begin
      if (req_data.first_of_scan) begin
         beam_sum = SUM_W'(req_data.scan_start_angle);
      end else begin
         beam_sum = SUM_W'(beam_ff) + SUM_W'(req_data.angle_step);
      end
   end

   // Masking tests against the register windows (inclusive bounds).
   assign angle_ok = (SUM_W'(beam_ff) >= SUM_W'(cfg.angle_min)) &&
                     (SUM_W'(beam_ff) <= SUM_W'(cfg.angle_max));
   assign range_ok = (range_ff != '0) &&
                     (range_ff >= cfg.near_limit_mm) &&
                     (range_ff <= cfg.far_limit_mm);

   // Pre-scale of the range by the inverse rotation gain.
   assign gain_prod = GAIN_PROD_W'(range_ff) * GAIN_PROD_W'(INV_GAIN_Q30);

   // One restoring step of the heading-wrap reduction.
   assign wrap_sub = wrap_ff - (MOD_W'(FULL) << k_ff);

   // Fold the wrapped angle into +-90 degrees; the middle half negates.
   always_comb begin
      if (wrap_ff <= MOD_W'(QUARTER)) begin
         fold_angle = wrap_ff;
         fold_neg   = 1'b0;
      end else if (wrap_ff < MOD_W'(THREE_Q)) begin
         fold_angle = wrap_ff - MOD_W'(HALF);
         fold_neg   = 1'b1;
      end else begin
         fold_angle = wrap_ff - MOD_W'(FULL);
         fold_neg   = 1'b0;
      end
   end

   assign z_start          = CORDIC_Z_W'(fold_angle) <<< (ANGLE_Q_BITS - ANGLE_FRAC_BITS);
   assign x_start          = {{(CORDIC_XY_W - X0_W){1'b0}}, x0_ff};
   assign cordic_ctl.start = (state_ff == S_FOLD);

   // Drop the Q16 fraction and add the pose offset.
   assign fin_x = FIN_W'(xr_ff >>> ROUND_BITS) + FIN_W'(cfg.pose_x_mm);
   assign fin_y = FIN_W'(yr_ff >>> ROUND_BITS) + FIN_W'(cfg.pose_y_mm);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      beam_in      = beam_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      range_in     = range_ff;
      wrap_in      = wrap_ff;
      k_in         = k_ff;
      x0_in        = x0_ff;
      neg_in       = neg_ff;
      xr_in        = xr_ff;
      yr_in        = yr_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (beam_sum > SUM_W'(FULL)) begin
                  beam_in = ANGLE_W'(FULL);
               end else if (beam_sum < SUM_W'(-FULL)) begin
                  beam_in = ANGLE_W'(-FULL);
               end else begin
                  beam_in = beam_sum[ANGLE_W-1:0];
               end
               range_in = req_data.range_mm;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            x0_in   = gain_prod[GAIN_PROD_W-1:GAIN_SHIFT];
            wrap_in = MOD_W'(beam_ff) + MOD_W'(cfg.pose_heading) + MOD_W'(WRAPS * FULL);
            k_in    = MODK_W'(MOD_TOP);
            if (angle_ok && range_ok) begin
               state_in = S_MOD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MOD: begin
            if (!wrap_sub[MOD_W-1]) begin
               wrap_in = wrap_sub;
            end
            if (k_ff == '0) begin
               state_in = S_FOLD;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         S_FOLD: begin
            neg_in   = fold_neg;
            state_in = S_ROT;
         end
         S_ROT: begin
            if (cordic_sts.done) begin
               state_in = S_RND;
            end
         end
         S_RND: begin
            if (neg_ff) begin
               xr_in = RND_W'(2 ** (ROUND_BITS - 1)) - RND_W'(cx);
               yr_in = RND_W'(2 ** (ROUND_BITS - 1)) - RND_W'(cy);
            end else begin
               xr_in = RND_W'(cx) + RND_W'(2 ** (ROUND_BITS - 1));
               yr_in = RND_W'(cy) + RND_W'(2 ** (ROUND_BITS - 1));
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_in.point_x_mm   = sat_point(fin_x);
               rsp_in.point_y_mm   = sat_point(fin_y);
               rsp_in.point_sensor = cfg.sensor_tag;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State, beam angle and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         beam_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         beam_ff      <= beam_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_ff       <= rsp_in;
      end
   end

   // Working registers of the current item.
   always_ff @(posedge clock) begin
      range_ff <= range_in;
      wrap_ff  <= wrap_in;
      k_ff     <= k_in;
      x0_ff    <= x0_in;
      neg_ff   <= neg_in;
      xr_ff    <= xr_in;
      yr_ff    <= yr_in;
   end

endmodule

/* rtl/lpcm_check.sv */
// Port-level checks for the lidar point converter, bound to the top level.
module lpcm_check (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input lpcm_pkg::req_type             req_data,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input lpcm_pkg::rsp_type             rsp_data,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [lpcm_pkg::CFG_AW-1:0]   csr_paddr,
   input logic [lpcm_pkg::CFG_DW-1:0]   csr_pwdata,
   input logic [lpcm_pkg::CFG_DW-1:0]   csr_prdata,
   input logic                          csr_pready
);
   import lpcm_pkg::*;

   // A stalled point stays offered and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("point changed or dropped while stalled");

   // Work on one item blocks the next for at least the following cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an item was accepted");

   // Reset empties the output register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("point offered right after reset");

   // A new point is only loaded while the block is busy with an item.
   a_point_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("point appeared while the block was idle");

endmodule

bind lidar_polar_to_cartesian_masker lpcm_check u_lpcm_check (.*);
